// File: rtl/call_arc_count_table_unit_macros.svh
// Assertion macros for the call arc counter.
// Used inside modules that have clk_i and an active-low rst_ni.
`ifndef CALL_ARC_COUNT_TABLE_UNIT_MACROS_SVH
`define CALL_ARC_COUNT_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset
`define CACT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define CACT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cact_pkg.sv
// Types and constants of the call arc counter.
// No dependencies; used by call_arc_count_table_unit.
`default_nettype none

package cact_pkg;

  // Arc table geometry
  localparam int ARC_IW      = 10;
  localparam int ARC_ENTRIES = 1024;
  localparam int ALLOC_W     = 11;
  localparam int STEP_W      = 11;
  localparam int CFG_IW      = 1;
  localparam int CFG_DW      = 32;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_REGION_BASE = 1'd0;
  localparam logic [CFG_IW-1:0] REG_ARC_LIMIT   = 1'd1;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_HEAD   = 2'd1,
    FUNC_ENTRY  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_HEAD_HIT = 3'd0,
    ST_MOVED    = 3'd1,
    ST_NEW      = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_RANGE    = 3'd4,
    ST_READ     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_SLOT,
    S_HEAD,
    S_WALK,
    S_MOVE,
    S_ALLOC,
    S_READ
  } state_e;

  // One arc as held in the arc memory
  typedef struct packed {
    logic [31:0]       callee;
    logic [31:0]       count;
    logic [ARC_IW-1:0] link;
  } arc_word_t;

endpackage

`default_nettype wire

// File: rtl/call_arc_count_table_unit.sv
// Call arc counter, top level: head memory, arc memory and the walk sequencer.
// Depends on cact_pkg, cact_ram and call_arc_count_table_unit_macros.svh.
//
// After reset the block clears the chain-head memory in S_CLEAR, with busy
// high; configuration writes are taken meanwhile. One item is worked at a
// time, all state living in a head memory and an arc memory, each with a
// registered read. An entry read passes S_READ and then the registered done_o;
// a head read first passes S_MUL, S_SLOT and S_HEAD. A record item passes
// the same states for slot arithmetic and the head fetch, then walks the
// chain in S_WALK, one arc at a time (arc memory read latency bounds this
// loop), then goes to S_ALLOC to allocate on a miss or to S_MOVE to relink on
// a hit beyond the front; a hit at the chain front emits its result from
// S_WALK. Each result shows for one cycle only and must be taken then;
// busy is low in that cycle, so the next item may start with it.
`default_nettype none

`include "call_arc_count_table_unit_macros.svh"

module call_arc_count_table_unit #(
  parameter int HEAD_SLOTS = 4096,
  parameter int SLOT_BYTES = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [cact_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  wire logic [cact_pkg::CFG_DW-1:0]  cfg_data_i,
  // command
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   func_i,
  input  wire logic [31:0]                  caller_pc_i,
  input  wire logic [31:0]                  callee_pc_i,
  input  wire logic [cact_pkg::ARC_IW-1:0]  entry_index_i,
  // result
  output logic                              done_o,
  output logic [2:0]                        status_o,
  output logic [cact_pkg::ARC_IW-1:0]       arc_index_o,
  output logic [31:0]                       arc_callee_o,
  output logic [31:0]                       arc_count_o,
  output logic [cact_pkg::ARC_IW-1:0]       arc_next_o
);

  import cact_pkg::*;

  // Slot arithmetic: slot = offset / SLOT_BYTES via a reciprocal and one fix-up
  localparam int SW    = $clog2(HEAD_SLOTS);
  localparam int LIMIT = HEAD_SLOTS * SLOT_BYTES;
  localparam int OW    = $clog2(LIMIT);
  localparam int RECIP = (2 ** OW) / SLOT_BYTES;
  localparam int MW    = OW + 1;
  localparam int PW    = OW + MW;
  localparam int AAW   = $clog2(ARC_ENTRIES);

  state_e              state_q, state_d;
  logic [SW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [31:0]         region_base_q, region_base_d;
  logic [ALLOC_W-1:0]  arc_limit_q, arc_limit_d;
  logic [ALLOC_W-1:0]  last_alloc_q, last_alloc_d;

  logic                is_rec_q, is_rec_d;
  logic [OW-1:0]       off_q, off_d;
  logic                in_range_q, in_range_d;
  logic [PW-1:0]       prod_q, prod_d;
  logic [31:0]         callee_q, callee_d;
  logic [SW-1:0]       slot_q, slot_d;
  logic [ARC_IW-1:0]   head_q, head_d;
  logic [ARC_IW-1:0]   cur_q, cur_d;
  logic [ARC_IW-1:0]   prev_q, prev_d;
  arc_word_t           prev_word_q, prev_word_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  logic [31:0]         hit_cnt_q, hit_cnt_d;

  logic                done_q;
  status_e             status_q;
  logic [ARC_IW-1:0]   idx_q;
  logic [31:0]         rcallee_q, rcount_q;
  logic [ARC_IW-1:0]   rnext_q;

  // memory ports
  logic                head_we;
  logic [SW-1:0]       head_waddr, head_raddr;
  logic [ARC_IW-1:0]   head_wdata, head_rdata;
  logic                arc_we;
  logic [AAW-1:0]      arc_waddr, arc_raddr;
  arc_word_t           arc_wdata, arc_rdata;

  // result to be registered
  logic                emit;
  status_e             e_status;
  logic [ARC_IW-1:0]   e_idx;
  logic [31:0]         e_callee, e_count;
  logic [ARC_IW-1:0]   e_next;

  logic [31:0]         offset;
  logic [SW-1:0]       q_est, slot_calc;
  logic [OW-1:0]       qd, rem;
  logic [ALLOC_W:0]    cand;
  logic                cand_ovf;

  assign offset    = caller_pc_i - region_base_q;
  assign q_est     = prod_q[OW +: SW];
  assign qd        = OW'(q_est) * OW'(SLOT_BYTES);
  assign rem       = off_q - qd;
  assign slot_calc = q_est + SW'(rem >= OW'(SLOT_BYTES));
  assign cand      = {1'b0, last_alloc_q} + (ALLOC_W + 1)'(1);
  assign cand_ovf  = (cand >= {1'b0, arc_limit_q}) || (cand >= (ALLOC_W + 1)'(ARC_ENTRIES));

  cact_ram #(
    .WIDTH (ARC_IW),
    .DEPTH (HEAD_SLOTS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  cact_ram #(
    .WIDTH ($bits(arc_word_t)),
    .DEPTH (ARC_ENTRIES)
  ) u_arc_ram (
    .clk_i   (clk_i),
    .we_i    (arc_we),
    .waddr_i (arc_waddr),
    .wdata_i (arc_wdata),
    .raddr_i (arc_raddr),
    .rdata_o (arc_rdata)
  );

  // Sequencer: next state, memory accesses and result
  always_comb begin
    state_d       = state_q;
    clr_cnt_d     = clr_cnt_q;
    region_base_d = region_base_q;
    arc_limit_d   = arc_limit_q;
    last_alloc_d  = last_alloc_q;
    is_rec_d      = is_rec_q;
    off_d         = off_q;
    in_range_d    = in_range_q;
    prod_d        = prod_q;
    callee_d      = callee_q;
    slot_d        = slot_q;
    head_d        = head_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    prev_word_d   = prev_word_q;
    steps_d       = steps_q;
    hit_cnt_d     = hit_cnt_q;

    head_we    = 1'b0;
    head_waddr = slot_q;
    head_wdata = cur_q;
    head_raddr = slot_q;
    arc_we     = 1'b0;
    arc_waddr  = AAW'(cur_q);
    arc_wdata  = arc_rdata;
    arc_raddr  = AAW'(cur_q);

    emit     = 1'b0;
    e_status = ST_READ;
    e_idx    = '0;
    e_callee = '0;
    e_count  = '0;
    e_next   = '0;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REGION_BASE: region_base_d = cfg_data_i;
        REG_ARC_LIMIT:   arc_limit_d   = cfg_data_i[ALLOC_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      // clearing pass over the head memory
      S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt_q;
        head_wdata = '0;
        if (clr_cnt_q == SW'(HEAD_SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + SW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          case (func_i)
            FUNC_RECORD, FUNC_HEAD: begin
              is_rec_d   = (func_i == FUNC_RECORD);
              off_d      = offset[OW-1:0];
              in_range_d = offset < 32'(LIMIT);
              callee_d   = callee_pc_i;
              state_d    = S_MUL;
            end
            FUNC_ENTRY: begin
              cur_d     = entry_index_i;
              arc_raddr = AAW'(entry_index_i);
              state_d   = S_READ;
            end
            default: ;
          endcase
        end
      end

      S_MUL: begin
        prod_d  = PW'(off_q) * PW'(RECIP);
        state_d = S_SLOT;
      end

      // quotient fix-up and head fetch
      S_SLOT: begin
        if (!in_range_q) begin
          emit     = 1'b1;
          e_status = ST_RANGE;
          state_d  = S_IDLE;
        end else begin
          slot_d     = slot_calc;
          head_raddr = slot_calc;
          state_d    = S_HEAD;
        end
      end

      S_HEAD: begin
        head_d    = head_rdata;
        cur_d     = head_rdata;
        arc_raddr = AAW'(head_rdata);
        steps_d   = '0;
        if (!is_rec_q) begin
          state_d = S_READ;
        end else if (head_rdata == '0) begin
          state_d = S_ALLOC;
        end else begin
          state_d = S_WALK;
        end
      end

      // one arc per cycle; arc_rdata holds entry cur_q
      S_WALK: begin
        if (arc_rdata.callee == callee_q) begin
          if (steps_q == '0) begin
            // hit at the front: bump in place
            arc_we           = 1'b1;
            arc_waddr        = AAW'(cur_q);
            arc_wdata        = arc_rdata;
            arc_wdata.count  = arc_rdata.count + 32'd1;
            emit     = 1'b1;
            e_status = ST_HEAD_HIT;
            e_idx    = cur_q;
            e_callee = arc_rdata.callee;
            e_count  = arc_rdata.count + 32'd1;
            e_next   = arc_rdata.link;
            state_d  = S_IDLE;
          end else begin
            // unlink from prev now, rewrite the hit arc next cycle
            arc_we          = 1'b1;
            arc_waddr       = AAW'(prev_q);
            arc_wdata       = prev_word_q;
            arc_wdata.link  = arc_rdata.link;
            head_we         = 1'b1;
            head_waddr      = slot_q;
            head_wdata      = cur_q;
            hit_cnt_d       = arc_rdata.count + 32'd1;
            state_d         = S_MOVE;
          end
        end else if (arc_rdata.link != '0 && steps_q < STEP_W'(ARC_ENTRIES)) begin
          prev_d      = cur_q;
          prev_word_d = arc_rdata;
          cur_d       = arc_rdata.link;
          arc_raddr   = AAW'(arc_rdata.link);
          steps_d     = steps_q + STEP_W'(1);
        end else begin
          state_d = S_ALLOC;
        end
      end

      S_MOVE: begin
        arc_we           = 1'b1;
        arc_waddr        = AAW'(cur_q);
        arc_wdata.callee = callee_q;
        arc_wdata.count  = hit_cnt_q;
        arc_wdata.link   = head_q;
        emit     = 1'b1;
        e_status = ST_MOVED;
        e_idx    = cur_q;
        e_callee = callee_q;
        e_count  = hit_cnt_q;
        e_next   = head_q;
        state_d  = S_IDLE;
      end

      // new arc at the chain front unless the table is full; allocation index saturates
      S_ALLOC: begin
        last_alloc_d = cand[ALLOC_W] ? {ALLOC_W{1'b1}} : cand[ALLOC_W-1:0];
        emit         = 1'b1;
        state_d      = S_IDLE;
        if (cand_ovf) begin
          e_status = ST_OVERFLOW;
        end else begin
          arc_we           = 1'b1;
          arc_waddr        = cand[AAW-1:0];
          arc_wdata.callee = callee_q;
          arc_wdata.count  = 32'd1;
          arc_wdata.link   = head_q;
          head_we          = 1'b1;
          head_waddr       = slot_q;
          head_wdata       = cand[ARC_IW-1:0];
          e_status = ST_NEW;
          e_idx    = cand[ARC_IW-1:0];
          e_callee = callee_q;
          e_count  = 32'd1;
          e_next   = head_q;
        end
      end

      // head or entry read; index zero means no arc
      S_READ: begin
        emit     = 1'b1;
        e_status = ST_READ;
        e_idx    = cur_q;
        if (cur_q != '0) begin
          e_callee = arc_rdata.callee;
          e_count  = arc_rdata.count;
          e_next   = arc_rdata.link;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      region_base_q <= '0;
      arc_limit_q   <= ALLOC_W'(ARC_ENTRIES);
      last_alloc_q  <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_cnt_q     <= clr_cnt_d;
      region_base_q <= region_base_d;
      arc_limit_q   <= arc_limit_d;
      last_alloc_q  <= last_alloc_d;
      done_q        <= emit;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    is_rec_q    <= is_rec_d;
    off_q       <= off_d;
    in_range_q  <= in_range_d;
    prod_q      <= prod_d;
    callee_q    <= callee_d;
    slot_q      <= slot_d;
    head_q      <= head_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    prev_word_q <= prev_word_d;
    steps_q     <= steps_d;
    hit_cnt_q   <= hit_cnt_d;
    if (emit) begin
      status_q  <= e_status;
      idx_q     <= e_idx;
      rcallee_q <= e_callee;
      rcount_q  <= e_count;
      rnext_q   <= e_next;
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign arc_index_o  = idx_q;
  assign arc_callee_o = rcallee_q;
  assign arc_count_o  = rcount_q;
  assign arc_next_o   = rnext_q;

  // Checks
  `CACT_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobed while busy")
  `CACT_ASSERT_NXT(a_accept_busy, start && !busy && func_i != FUNC_NONE, busy,
                   "accepted item did not raise busy")
  `CACT_ASSERT_NXT(a_alloc_mono, 1'b1, last_alloc_q >= $past(last_alloc_q),
                   "allocation index went backwards")
  `CACT_ASSERT_IMP(a_new_count, done_o && status_o == ST_NEW,
                   arc_count_o == 32'd1 && arc_index_o != '0, "new arc result malformed")
  `CACT_ASSERT_IMP(a_blank, done_o && (status_o == ST_OVERFLOW || status_o == ST_RANGE),
                   arc_index_o == '0 && arc_count_o == '0, "blank result carries data")

endmodule

`default_nettype wire

// File: rtl/cact_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module cact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
